>>> hw/rtl/tpmm_pkg.sv
// Shared types, constants and helpers of the tiled phase min/max unit.
package tpmm_pkg;

   localparam int DIM_W  = 14;
   localparam int PIX_W  = 13;
   localparam int TILE_W = 6;
   localparam int PH_W   = 24;
   localparam int PROD_W = DIM_W + TILE_W + 1;

   localparam logic [PH_W-1:0]  INVALID_LO     = 24'd255975;
   localparam logic [PH_W-1:0]  INVALID_HI     = 24'd256025;
   localparam logic [PH_W-1:0]  FRAME_MIN_INIT = 24'd255974;
   localparam logic [DIM_W-1:0] RESET_WIDTH    = 14'd1280;
   localparam logic [DIM_W-1:0] RESET_HEIGHT   = 14'd720;

   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   typedef struct packed {
      logic [PH_W-1:0] h_phase;
      logic [PH_W-1:0] v_phase;
   } req_type;

   typedef struct packed {
      logic [TILE_W-1:0] tile_col;
      logic [TILE_W-1:0] tile_row;
      logic [PH_W-1:0]   tile_h_max;
      logic [PH_W-1:0]   tile_h_min;
      logic [PH_W-1:0]   tile_v_max;
      logic [PH_W-1:0]   tile_v_min;
      logic [PH_W-1:0]   frame_h_max;
      logic [PH_W-1:0]   frame_h_min;
      logic [PH_W-1:0]   frame_v_max;
      logic [PH_W-1:0]   frame_v_min;
      logic              last_of_run;
      logic              frame_done;
   } rsp_type;

   typedef struct packed {
      logic [PH_W-1:0] hmax;
      logic [PH_W-1:0] hmin;
      logic [PH_W-1:0] vmax;
      logic [PH_W-1:0] vmin;
   } ent_type;

   typedef struct packed {
      logic col2;
      logic row2;
      logic col_adv;
      logic tile_end;
      logic row_last;
      logic row_end;
      logic frame_end;
   } geo_type;

   typedef enum logic [3:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_MUL,
      ST_CMP,
      ST_RD,
      ST_WR,
      ST_POST,
      ST_ERD,
      ST_ELOAD
   } st_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d,
                                                  input logic [DIM_W-1:0] hi);
      if (d < 14'd2) return 14'd2;
      if (d > hi) return hi;
      return d;
   endfunction

   function automatic logic phase_ok(input logic [PH_W-1:0] p);
      return (p < INVALID_LO) || (p > INVALID_HI);
   endfunction

endpackage

>>> hw/rtl/tpmm_ram.sv
// Generic simple dual-port RAM with registered read.
module tpmm_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/tpmm_geom.sv
// Tile edge geometry: products and edge compares for the current pixel.
module tpmm_geom #(
   parameter int TILES = 16
) (
   input  logic                         clock,
   input  logic                         capture,
   input  logic [tpmm_pkg::DIM_W-1:0]   width,
   input  logic [tpmm_pkg::DIM_W-1:0]   height,
   input  logic [tpmm_pkg::PIX_W-1:0]   pix_col,
   input  logic [tpmm_pkg::PIX_W-1:0]   pix_row,
   input  logic [tpmm_pkg::TILE_W-1:0]  tile_col,
   input  logic [tpmm_pkg::TILE_W-1:0]  tile_row,
   output tpmm_pkg::geo_type            flags
);

   localparam int PW = tpmm_pkg::PROD_W;
   localparam int DW = tpmm_pkg::DIM_W;
   localparam int KW = tpmm_pkg::TILE_W + 1;

   logic [DW-1:0] deff_w, deff_h;
   logic [KW-1:0] kc, kr;
   logic [PW-1:0] xc_ff, ac_ff, xr_ff, ar_ff;
   logic [PW-1:0] nc, nr;
   tpmm_pkg::geo_type flags_ff, flags_in;

   assign deff_w = (width > DW'(TILES)) ? width : DW'(TILES + 1);
   assign deff_h = (height > DW'(TILES)) ? height : DW'(TILES + 1);
   assign kc = KW'(tile_col) + KW'(1);
   assign kr = KW'(tile_row) + KW'(1);

   always_ff @(posedge clock) begin
      xc_ff <= PW'(deff_w) * PW'(kc);
      ac_ff <= PW'(pix_col) * PW'(TILES);
      xr_ff <= PW'(deff_h) * PW'(kr);
      ar_ff <= PW'(pix_row) * PW'(TILES);
      if (capture) begin
         flags_ff <= flags_in;
      end
   end

   assign nc = ac_ff + PW'(TILES);
   assign nr = ar_ff + PW'(TILES);

   always_comb begin
      flags_in.col2      = (kc < KW'(TILES)) && (ac_ff <= xc_ff) && (xc_ff < nc);
      flags_in.col_adv   = (kc < KW'(TILES)) && (nc > xc_ff);
      flags_in.row2      = (kr < KW'(TILES)) && (ar_ff <= xr_ff) && (xr_ff < nr);
      flags_in.tile_end  = nr > xr_ff;
      flags_in.row_last  = !(kr < KW'(TILES));
      flags_in.row_end   = DW'(pix_col) >= (width - DW'(1));
      flags_in.frame_end = DW'(pix_row) >= (height - DW'(1));
   end

   assign flags = flags_ff;

endmodule

>>> hw/rtl/tiled_phase_min_max_unit.sv
// Top level: tiled phase min/max statistics over a raster pixel stream.
// A pixel is taken in the idle state, then the unit stalls while it updates t tile
// entries (1 to 4) by read-modify-write on the one RAM; a tile row end emits TILES
// records (2*TILES on a frame end whose last row also starts a tile row), one at a
// time as the output frees, then sweeps TILES entries (2*TILES on a frame end) to
// reload. Synchronous active-high reset sweeps 2*TILES RAM entries before the first
// pixel is taken; configuration writes are taken throughout.
module tiled_phase_min_max_unit #(
   parameter int TILES_PER_SIDE = 16,
   parameter int MAX_DIM        = 8192
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  tpmm_pkg::req_type           req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output tpmm_pkg::rsp_type           rsp_payload,
   input  logic                        csr_we,
   input  logic                        csr_index,
   input  logic [tpmm_pkg::DIM_W-1:0]  csr_wdata
);

   localparam int TIW   = (TILES_PER_SIDE > 1) ? $clog2(TILES_PER_SIDE) : 1;
   localparam int DEPTH = 2 << TIW;
   localparam int AW    = TIW + 1;
   localparam int EW    = 4 * tpmm_pkg::PH_W;
   localparam int DW    = tpmm_pkg::DIM_W;
   localparam int PXW   = tpmm_pkg::PIX_W;
   localparam int TW    = tpmm_pkg::TILE_W;
   localparam int PHW   = tpmm_pkg::PH_W;
   localparam logic [TIW-1:0] LAST_IDX = TIW'(TILES_PER_SIDE - 1);

   tpmm_pkg::st_type state_ff, state_in;

   logic [DW-1:0]  csr_w_ff, csr_w_in, csr_h_ff, csr_h_in, w_cl, h_cl;
   logic [PXW-1:0] pix_col_ff, pix_col_in, pix_row_ff, pix_row_in;
   logic [TW-1:0]  tcol_ff, tcol_in, trow_ff, trow_in;
   logic           sel_ff, sel_in;
   logic [1:0]     tgt_ff, tgt_in;
   logic           ebank_ff, ebank_in;
   logic [TIW-1:0] eidx_ff, eidx_in, sw_idx_ff, sw_idx_in;
   logic           sw_bank_ff, sw_bank_in, sw_two_ff, sw_two_in;
   logic [PHW-1:0] init_h_ff, init_h_in, init_v_ff, init_v_in;
   logic [PHW-1:0] g_hmax_ff, g_hmax_in, g_hmin_ff, g_hmin_in;
   logic [PHW-1:0] g_vmax_ff, g_vmax_in, g_vmin_ff, g_vmin_in;
   logic [PHW-1:0] hp_ff, hp_in, vp_ff, vp_in;
   tpmm_pkg::rsp_type rsp_ff, rsp_in;
   logic           rsp_valid_ff, rsp_valid_in;

   tpmm_pkg::geo_type geo;
   tpmm_pkg::ent_type rd_ent, mod_ent, init_ent;
   logic [EW-1:0]  ram_rdata, ram_wdata;
   logic [AW-1:0]  ram_raddr, ram_waddr, tgt_addr;
   logic           ram_we, geo_cap;
   logic           has_next, rsp_free, rec_last;
   logic [1:0]     next_tgt;
   logic [TW:0]    tgt_tile;

   assign w_cl = tpmm_pkg::clamp_dim(csr_w_ff, DW'(MAX_DIM));
   assign h_cl = tpmm_pkg::clamp_dim(csr_h_ff, DW'(MAX_DIM));

   tpmm_geom #(.TILES(TILES_PER_SIDE)) u_geom (
      .clock    (clock),
      .capture  (geo_cap),
      .width    (w_cl),
      .height   (h_cl),
      .pix_col  (pix_col_ff),
      .pix_row  (pix_row_ff),
      .tile_col (tcol_ff),
      .tile_row (trow_ff),
      .flags    (geo)
   );

   tpmm_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_ent   = tpmm_pkg::ent_type'(ram_rdata);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign rec_last = (eidx_ff == LAST_IDX) && (ebank_ff || !(geo.frame_end && geo.row2));

   // target entries of one pixel: current tile, right neighbor, same two in the next row
   assign tgt_tile = tgt_ff[0] ? ((TW + 1)'(tcol_ff) + (TW + 1)'(1)) : (TW + 1)'(tcol_ff);
   assign tgt_addr = {sel_ff ^ tgt_ff[1], tgt_tile[TIW-1:0]};

   always_comb begin
      has_next = 1'b0;
      next_tgt = tgt_ff;
      case (tgt_ff)
         2'd0: begin
            if (geo.col2) begin
               has_next = 1'b1;
               next_tgt = 2'd1;
            end else if (geo.row2) begin
               has_next = 1'b1;
               next_tgt = 2'd2;
            end
         end
         2'd1: begin
            if (geo.row2) begin
               has_next = 1'b1;
               next_tgt = 2'd2;
            end
         end
         2'd2: begin
            if (geo.col2) begin
               has_next = 1'b1;
               next_tgt = 2'd3;
            end
         end
         default: begin
            has_next = 1'b0;
         end
      endcase
   end

   always_comb begin
      mod_ent = rd_ent;
      if (tpmm_pkg::phase_ok(hp_ff)) begin
         if (hp_ff > rd_ent.hmax) mod_ent.hmax = hp_ff;
         if (hp_ff < rd_ent.hmin) mod_ent.hmin = hp_ff;
      end
      if (tpmm_pkg::phase_ok(vp_ff)) begin
         if (vp_ff > rd_ent.vmax) mod_ent.vmax = vp_ff;
         if (vp_ff < rd_ent.vmin) mod_ent.vmin = vp_ff;
      end
      init_ent.hmax = '0;
      init_ent.hmin = init_h_ff;
      init_ent.vmax = '0;
      init_ent.vmin = init_v_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tpmm_pkg::ST_SWEEP: begin
            if (sw_idx_ff == LAST_IDX && !sw_two_ff) state_in = tpmm_pkg::ST_IDLE;
         end
         tpmm_pkg::ST_IDLE: begin
            if (req_valid) state_in = tpmm_pkg::ST_MUL;
         end
         tpmm_pkg::ST_MUL:  state_in = tpmm_pkg::ST_CMP;
         tpmm_pkg::ST_CMP:  state_in = tpmm_pkg::ST_RD;
         tpmm_pkg::ST_RD:   state_in = tpmm_pkg::ST_WR;
         tpmm_pkg::ST_WR: begin
            state_in = has_next ? tpmm_pkg::ST_RD : tpmm_pkg::ST_POST;
         end
         tpmm_pkg::ST_POST: begin
            if (geo.row_end && (geo.frame_end || geo.tile_end)) state_in = tpmm_pkg::ST_ERD;
            else state_in = tpmm_pkg::ST_IDLE;
         end
         tpmm_pkg::ST_ERD: begin
            if (rsp_free) state_in = tpmm_pkg::ST_ELOAD;
         end
         tpmm_pkg::ST_ELOAD: begin
            state_in = rec_last ? tpmm_pkg::ST_SWEEP : tpmm_pkg::ST_ERD;
         end
         default: state_in = tpmm_pkg::ST_IDLE;
      endcase
   end

   // outputs and memory control
   always_comb begin
      req_stall = 1'b1;
      geo_cap   = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = tgt_addr;
      ram_wdata = mod_ent;
      ram_raddr = {sel_ff ^ ebank_ff, eidx_ff};
      case (state_ff)
         tpmm_pkg::ST_IDLE: req_stall = 1'b0;
         tpmm_pkg::ST_CMP:  geo_cap = 1'b1;
         tpmm_pkg::ST_RD:   ram_raddr = tgt_addr;
         tpmm_pkg::ST_WR:   ram_we = 1'b1;
         tpmm_pkg::ST_SWEEP: begin
            ram_we    = 1'b1;
            ram_waddr = {sw_bank_ff, sw_idx_ff};
            ram_wdata = init_ent;
         end
         default: req_stall = 1'b1;
      endcase
   end

   // datapath next values
   always_comb begin
      csr_w_in     = csr_w_ff;
      csr_h_in     = csr_h_ff;
      pix_col_in   = pix_col_ff;
      pix_row_in   = pix_row_ff;
      tcol_in      = tcol_ff;
      trow_in      = trow_ff;
      sel_in       = sel_ff;
      tgt_in       = tgt_ff;
      ebank_in     = ebank_ff;
      eidx_in      = eidx_ff;
      sw_idx_in    = sw_idx_ff;
      sw_bank_in   = sw_bank_ff;
      sw_two_in    = sw_two_ff;
      init_h_in    = init_h_ff;
      init_v_in    = init_v_ff;
      g_hmax_in    = g_hmax_ff;
      g_hmin_in    = g_hmin_ff;
      g_vmax_in    = g_vmax_ff;
      g_vmin_in    = g_vmin_ff;
      hp_in        = hp_ff;
      vp_in        = vp_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (csr_we) begin
         case (csr_index)
            tpmm_pkg::REG_WIDTH:  csr_w_in = csr_wdata;
            tpmm_pkg::REG_HEIGHT: csr_h_in = csr_wdata;
            default: csr_w_in = csr_w_ff;
         endcase
      end

      case (state_ff)
         tpmm_pkg::ST_IDLE: begin
            hp_in = req_payload.h_phase;
            vp_in = req_payload.v_phase;
         end
         tpmm_pkg::ST_CMP: tgt_in = 2'd0;
         tpmm_pkg::ST_WR:  tgt_in = next_tgt;
         tpmm_pkg::ST_POST: begin
            ebank_in = 1'b0;
            eidx_in  = '0;
            if (geo.col_adv) tcol_in = tcol_ff + TW'(1);
            if (geo.row_end) begin
               pix_col_in = '0;
               tcol_in    = '0;
               pix_row_in = geo.frame_end ? '0 : pix_row_ff + PXW'(1);
            end else begin
               pix_col_in = pix_col_ff + PXW'(1);
            end
         end
         tpmm_pkg::ST_ELOAD: begin
            if (g_hmax_ff < rd_ent.hmax) g_hmax_in = rd_ent.hmax;
            if (g_hmin_ff > rd_ent.hmin) g_hmin_in = rd_ent.hmin;
            if (g_vmax_ff < rd_ent.vmax) g_vmax_in = rd_ent.vmax;
            if (g_vmin_ff > rd_ent.vmin) g_vmin_in = rd_ent.vmin;
            rsp_in.tile_col    = TW'(eidx_ff);
            rsp_in.tile_row    = trow_ff + TW'(ebank_ff);
            rsp_in.tile_h_max  = rd_ent.hmax;
            rsp_in.tile_h_min  = rd_ent.hmin;
            rsp_in.tile_v_max  = rd_ent.vmax;
            rsp_in.tile_v_min  = rd_ent.vmin;
            rsp_in.frame_h_max = g_hmax_in;
            rsp_in.frame_h_min = g_hmin_in;
            rsp_in.frame_v_max = g_vmax_in;
            rsp_in.frame_v_min = g_vmin_in;
            rsp_in.last_of_run = rec_last;
            rsp_in.frame_done  = rec_last && geo.frame_end;
            rsp_valid_in       = 1'b1;
            if (eidx_ff == LAST_IDX) begin
               eidx_in  = '0;
               ebank_in = 1'b1;
            end else begin
               eidx_in = eidx_ff + TIW'(1);
            end
            if (rec_last) begin
               sw_idx_in = '0;
               init_h_in = PHW'(w_cl) << 8;
               init_v_in = PHW'(h_cl) << 8;
               if (geo.frame_end) begin
                  sw_bank_in = 1'b0;
                  sw_two_in  = 1'b1;
                  trow_in    = '0;
                  g_hmax_in  = '0;
                  g_hmin_in  = tpmm_pkg::FRAME_MIN_INIT;
                  g_vmax_in  = '0;
                  g_vmin_in  = tpmm_pkg::FRAME_MIN_INIT;
               end else begin
                  sw_bank_in = sel_ff;
                  sw_two_in  = 1'b0;
                  if (!geo.row_last) begin
                     sel_in  = !sel_ff;
                     trow_in = trow_ff + TW'(1);
                  end
               end
            end
         end
         tpmm_pkg::ST_SWEEP: begin
            if (sw_idx_ff == LAST_IDX) begin
               sw_idx_in = '0;
               if (sw_two_ff) begin
                  sw_two_in  = 1'b0;
                  sw_bank_in = !sw_bank_ff;
               end
            end else begin
               sw_idx_in = sw_idx_ff + TIW'(1);
            end
         end
         default: tgt_in = tgt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tpmm_pkg::ST_SWEEP;
         csr_w_ff     <= tpmm_pkg::RESET_WIDTH;
         csr_h_ff     <= tpmm_pkg::RESET_HEIGHT;
         pix_col_ff   <= '0;
         pix_row_ff   <= '0;
         tcol_ff      <= '0;
         trow_ff      <= '0;
         sel_ff       <= 1'b0;
         tgt_ff       <= '0;
         ebank_ff     <= 1'b0;
         eidx_ff      <= '0;
         sw_idx_ff    <= '0;
         sw_bank_ff   <= 1'b0;
         sw_two_ff    <= 1'b1;
         init_h_ff    <= PHW'(tpmm_pkg::clamp_dim(tpmm_pkg::RESET_WIDTH, DW'(MAX_DIM))) << 8;
         init_v_ff    <= PHW'(tpmm_pkg::clamp_dim(tpmm_pkg::RESET_HEIGHT, DW'(MAX_DIM))) << 8;
         g_hmax_ff    <= '0;
         g_hmin_ff    <= tpmm_pkg::FRAME_MIN_INIT;
         g_vmax_ff    <= '0;
         g_vmin_ff    <= tpmm_pkg::FRAME_MIN_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         csr_w_ff     <= csr_w_in;
         csr_h_ff     <= csr_h_in;
         pix_col_ff   <= pix_col_in;
         pix_row_ff   <= pix_row_in;
         tcol_ff      <= tcol_in;
         trow_ff      <= trow_in;
         sel_ff       <= sel_in;
         tgt_ff       <= tgt_in;
         ebank_ff     <= ebank_in;
         eidx_ff      <= eidx_in;
         sw_idx_ff    <= sw_idx_in;
         sw_bank_ff   <= sw_bank_in;
         sw_two_ff    <= sw_two_in;
         init_h_ff    <= init_h_in;
         init_v_ff    <= init_v_in;
         g_hmax_ff    <= g_hmax_in;
         g_hmin_ff    <= g_hmin_in;
         g_vmax_ff    <= g_vmax_in;
         g_vmin_ff    <= g_vmin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hp_ff  <= hp_in;
      vp_ff  <= vp_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == tpmm_pkg::ST_ELOAD |-> !rsp_valid_ff)
      else $error("record loaded over a pending record");

   a_rise_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == tpmm_pkg::ST_ELOAD)
      else $error("record raised outside emission");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.frame_done |-> rsp_ff.last_of_run)
      else $error("frame end record not marked last");

   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> req_stall)
      else $error("request taken during memory write");

endmodule

>>> verif/tiled_phase_min_max_unit_tb.sv
// Testbench for the tiled phase min/max unit: randomized pixel stream checked against a tile model.
`timescale 1ns / 100ps

module tiled_phase_min_max_unit_tb;

   localparam int TILES  = 16;
   localparam int BANKS  = 2 * TILES;
   localparam int DIMMAX = 8192;
   localparam int DIM_W  = tpmm_pkg::DIM_W;
   localparam int PH_W   = tpmm_pkg::PH_W;
   localparam int TILE_W = tpmm_pkg::TILE_W;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   tpmm_pkg::req_type    req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   tpmm_pkg::rsp_type    rsp_payload;
   logic                 csr_we = 1'b0;
   logic                 csr_index = tpmm_pkg::REG_WIDTH;
   logic [DIM_W-1:0]     csr_wdata = '0;

   tiled_phase_min_max_unit #(.TILES_PER_SIDE(TILES), .MAX_DIM(DIMMAX)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   tpmm_pkg::req_type  pixels_to_send[$];
   tpmm_pkg::rsp_type  tile_records_due[$];
   int          pixels_sent = 0;
   int          records_seen = 0;
   int          mismatches = 0;
   int          frames_seen = 0;
   bit          long_hold_done = 0;
   int          hold_left = 0;

   // tile statistics model
   logic [DIM_W-1:0] cfg_width, cfg_height;
   logic [PH_W-1:0]  m_hmax[BANKS], m_hmin[BANKS], m_vmax[BANKS], m_vmin[BANKS];
   int unsigned      m_col, m_row, m_tcol, m_trow;
   logic [PH_W-1:0]  g_hmax, g_hmin, g_vmax, g_vmin;

   function automatic int unsigned sat_dim(logic [DIM_W-1:0] d);
      if (d < 2) return 2;
      if (d > DIMMAX) return DIMMAX;
      return d;
   endfunction

   function automatic int unsigned tile_edge(int unsigned k, int unsigned d);
      int unsigned deff;
      deff = (d > TILES) ? d : TILES + 1;
      return (deff * k) / TILES;
   endfunction

   task automatic load_bank(int base);
      for (int i = 0; i < TILES; i++) begin
         m_hmax[base+i] = '0;
         m_hmin[base+i] = PH_W'(sat_dim(cfg_width) << 8);
         m_vmax[base+i] = '0;
         m_vmin[base+i] = PH_W'(sat_dim(cfg_height) << 8);
      end
   endtask

   task automatic restart_frame();
      load_bank(0);
      load_bank(TILES);
      m_col = 0; m_row = 0; m_tcol = 0; m_trow = 0;
      g_hmax = '0; g_hmin = tpmm_pkg::FRAME_MIN_INIT;
      g_vmax = '0; g_vmin = tpmm_pkg::FRAME_MIN_INIT;
   endtask

   task automatic merge_pixel(int unsigned idx, logic [PH_W-1:0] hp, logic [PH_W-1:0] vp);
      if (idx >= BANKS) return;
      if (hp < tpmm_pkg::INVALID_LO || hp > tpmm_pkg::INVALID_HI) begin
         if (hp > m_hmax[idx]) m_hmax[idx] = hp;
         if (hp < m_hmin[idx]) m_hmin[idx] = hp;
      end
      if (vp < tpmm_pkg::INVALID_LO || vp > tpmm_pkg::INVALID_HI) begin
         if (vp > m_vmax[idx]) m_vmax[idx] = vp;
         if (vp < m_vmin[idx]) m_vmin[idx] = vp;
      end
   endtask

   task automatic queue_tile_row(int base, int unsigned trow);
      tpmm_pkg::rsp_type r;
      for (int i = 0; i < TILES; i++) begin
         if (g_hmax < m_hmax[base+i]) g_hmax = m_hmax[base+i];
         if (g_hmin > m_hmin[base+i]) g_hmin = m_hmin[base+i];
         if (g_vmax < m_vmax[base+i]) g_vmax = m_vmax[base+i];
         if (g_vmin > m_vmin[base+i]) g_vmin = m_vmin[base+i];
         r.tile_col = TILE_W'(i);
         r.tile_row = TILE_W'(trow);
         r.tile_h_max = m_hmax[base+i];
         r.tile_h_min = m_hmin[base+i];
         r.tile_v_max = m_vmax[base+i];
         r.tile_v_min = m_vmin[base+i];
         r.frame_h_max = g_hmax;
         r.frame_h_min = g_hmin;
         r.frame_v_max = g_vmax;
         r.frame_v_min = g_vmin;
         r.last_of_run = 1'b0;
         r.frame_done = 1'b0;
         tile_records_due = {tile_records_due, r};
      end
   endtask

   task automatic mark_last(bit done);
      int tail;
      tail = tile_records_due.size() - 1;
      tile_records_due[tail].last_of_run = 1'b1;
      tile_records_due[tail].frame_done = done;
   endtask

   task automatic predict_pixel(tpmm_pkg::req_type p);
      int unsigned w, h, c, rr, tc, tr;
      bit col2, row2;
      w = sat_dim(cfg_width);
      h = sat_dim(cfg_height);
      c = m_col; rr = m_row; tc = m_tcol; tr = m_trow;
      col2 = (tc + 1 < TILES) && (c == tile_edge(tc + 1, w));
      row2 = (tr + 1 < TILES) && (rr == tile_edge(tr + 1, h));
      merge_pixel(tc, p.h_phase, p.v_phase);
      if (col2) merge_pixel(tc + 1, p.h_phase, p.v_phase);
      if (row2) begin
         merge_pixel(TILES + tc, p.h_phase, p.v_phase);
         if (col2) merge_pixel(TILES + tc + 1, p.h_phase, p.v_phase);
      end
      if (tc + 1 < TILES && c >= tile_edge(tc + 1, w)) m_tcol = tc + 1;
      if (c < w - 1) begin
         m_col = c + 1;
         return;
      end
      m_col = 0;
      m_tcol = 0;
      if (rr >= h - 1) begin
         queue_tile_row(0, tr);
         if (row2) queue_tile_row(TILES, tr + 1);
         mark_last(1'b1);
         restart_frame();
         return;
      end
      if (rr >= tile_edge(tr + 1, h)) begin
         queue_tile_row(0, tr);
         mark_last(1'b0);
         if (tr + 1 < TILES) begin
            for (int i = 0; i < TILES; i++) begin
               m_hmax[i] = m_hmax[TILES+i];
               m_hmin[i] = m_hmin[TILES+i];
               m_vmax[i] = m_vmax[TILES+i];
               m_vmin[i] = m_vmin[TILES+i];
            end
            load_bank(TILES);
            m_trow = tr + 1;
         end else begin
            load_bank(0);
         end
      end
      m_row = rr + 1;
   endtask

   function automatic bit in_quiet_stretch();
      return pixels_sent >= 120 && pixels_sent < 170;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            predict_pixel(req_payload);
            pixels_sent++;
         end
         if (pixels_to_send.size() > 0 && (in_quiet_stretch() || $urandom_range(99) >= 12)) begin
            req_valid <= 1'b1;
            req_payload <= pixels_to_send.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      logic [PH_W-1:0] ev[12], av[12];
      string fname[12];
      tpmm_pkg::rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (tile_records_due.size() == 0) begin
            $display("%0t: unexpected tile record %p", $time, rsp_payload);
            mismatches++;
         end else begin
            e = tile_records_due.pop_front();
            fname = '{"tile_col", "tile_row", "tile_h_max", "tile_h_min", "tile_v_max",
                      "tile_v_min", "frame_h_max", "frame_h_min", "frame_v_max",
                      "frame_v_min", "last_of_run", "frame_done"};
            ev = '{PH_W'(e.tile_col), PH_W'(e.tile_row), e.tile_h_max, e.tile_h_min,
                   e.tile_v_max, e.tile_v_min, e.frame_h_max, e.frame_h_min,
                   e.frame_v_max, e.frame_v_min, PH_W'(e.last_of_run),
                   PH_W'(e.frame_done)};
            av = '{PH_W'(rsp_payload.tile_col), PH_W'(rsp_payload.tile_row),
                   rsp_payload.tile_h_max, rsp_payload.tile_h_min,
                   rsp_payload.tile_v_max, rsp_payload.tile_v_min,
                   rsp_payload.frame_h_max, rsp_payload.frame_h_min,
                   rsp_payload.frame_v_max, rsp_payload.frame_v_min,
                   PH_W'(rsp_payload.last_of_run), PH_W'(rsp_payload.frame_done)};
            for (int i = 0; i < 12; i++)
               if (ev[i] !== av[i]) begin
                  $display("%0t: %s expected %0d actual %0d", $time, fname[i], ev[i], av[i]);
                  mismatches++;
               end
            if (e.frame_done) frames_seen++;
         end
         records_seen++;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!long_hold_done && pixels_sent >= 40) begin
         long_hold_done <= 1'b1;
         hold_left <= 600;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !in_quiet_stretch() && ($urandom_range(99) < 12);
      end
   end

   task automatic settle();
      while (pixels_to_send.size() != 0 || req_valid || tile_records_due.size() != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [DIM_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == tpmm_pkg::REG_WIDTH) cfg_width = val;
      else cfg_height = val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [PH_W-1:0] rand_phase();
      case ($urandom_range(5))
         0: return PH_W'($urandom_range(256030, 255970));
         1: return PH_W'($urandom_range(4000));
         default: return PH_W'($urandom);
      endcase
   endfunction

   task automatic add_pixel(logic [PH_W-1:0] hp, logic [PH_W-1:0] vp);
      tpmm_pkg::req_type p;
      p.h_phase = hp;
      p.v_phase = vp;
      pixels_to_send = {pixels_to_send, p};
   endtask

   task automatic run_frames(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h, int n);
      settle();
      write_reg(tpmm_pkg::REG_WIDTH, w);
      write_reg(tpmm_pkg::REG_HEIGHT, h);
      for (int i = 0; i < n; i++) add_pixel(rand_phase(), rand_phase());
   endtask

   initial begin
      logic [PH_W-1:0] corner[8];
      int unsigned w, h, n;
      cfg_width = tpmm_pkg::RESET_WIDTH;
      cfg_height = tpmm_pkg::RESET_HEIGHT;
      restart_frame();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset dimensions, phase extremes and the edges of the invalid band
      corner = '{24'd0, 24'hFFFFFF, 24'd255974, 24'd255975, 24'd256025, 24'd256026,
                 24'd256000, 24'd1};
      for (int i = 0; i < 8; i++) add_pixel(corner[i], corner[7-i]);
      // shrink mid frame, then saturate both dimensions low
      settle();
      write_reg(tpmm_pkg::REG_WIDTH, 14'd0);
      write_reg(tpmm_pkg::REG_HEIGHT, 14'd1);
      for (int i = 0; i < 8; i++) add_pixel(corner[i], corner[i]);
      run_frames(14'h3FFF, 14'd2, 4);
      run_frames(14'd8192, 14'h3FFF, 3);
      run_frames(14'd2, 14'd3, 2);

      while (pixels_sent + pixels_to_send.size() < 230) begin
         case ($urandom_range(9))
            0: begin w = 17; h = 2; end
            1: begin w = 16; h = 16; end
            2: begin w = 2; h = 17; end
            3: begin w = $urandom_range(40, 33); h = 2; end
            4: begin w = 2; h = 8192; end
            default: begin w = $urandom_range(6, 2); h = $urandom_range(6, 2); end
         endcase
         n = (w * h > 40) ? 20 + $urandom_range(20) : w * h * (1 + 40 / (w * h));
         if ($urandom_range(7) == 0) n = n + $urandom_range(5);
         run_frames(DIM_W'(w), DIM_W'(h), n);
      end
      settle();
      write_reg(tpmm_pkg::REG_WIDTH, tpmm_pkg::RESET_WIDTH);
      write_reg(tpmm_pkg::REG_HEIGHT, tpmm_pkg::RESET_HEIGHT);
      settle();

      $display("Sent %0d pixels over many frame sizes, checked %0d tile records, %0d frames.",
               pixels_sent, records_seen, frames_seen);
      if (mismatches == 0 && tile_records_due.size() == 0) begin
         $display("tiled_phase_min_max_unit verification clean");
      end else begin
         $display("tiled_phase_min_max_unit verification failed");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("tiled_phase_min_max_unit verification failed");
      $finish;
   end

endmodule
